// File: design/dspid_pkg.sv
// Package for the differential steering PID block: fixed-point constants,
// register indexes and the sequencer state type. Depends on nothing.

package dspid_pkg;

  localparam int unsigned ErrFracBits = 14;
  localparam int unsigned SpdFracBits = 8;
  localparam int unsigned GainFracBits = 8;
  localparam int unsigned AlphaFracBits = 16;

  localparam int unsigned ErrW = 16;
  localparam int unsigned SpdW = 13;
  localparam int unsigned SumW = 20;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MulAW = 18;
  localparam int unsigned MulBW = 21;
  localparam int unsigned AccW = 40;
  localparam int unsigned TotW = 27;

  localparam int ErrOne = 1 << ErrFracBits;
  localparam int ErrThr = (ErrOne + 5) / 10;
  localparam int SumLim = 20 << ErrFracBits;
  localparam int SpdLim = 10 << SpdFracBits;
  localparam int TurnSpd = 3 << SpdFracBits;
  localparam int TotShift = GainFracBits + ErrFracBits - SpdFracBits;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_MIN   = 3'd0,
    REG_GAIN_MAX   = 3'd1,
    REG_DERIV_COEF = 3'd2,
    REG_INTEG_COEF = 3'd3,
    REG_CRUISE     = 3'd4,
    REG_ALPHA      = 3'd5,
    REG_PERIOD     = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_e;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_KP_MUL = 11'b000_0000_0010,
    S_KP     = 11'b000_0000_0100,
    S_P      = 11'b000_0000_1000,
    S_D      = 11'b000_0001_0000,
    S_I      = 11'b000_0010_0000,
    S_WHEEL  = 11'b000_0100_0000,
    S_F1     = 11'b000_1000_0000,
    S_F2     = 11'b001_0000_0000,
    S_FILT   = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

endpackage

// File: design/differential_steering_pid_with_search_top.sv
// Top level of the differential steering PID block with line search.
// One shared multiply-accumulate unit runs under a one-hot sequencer.
// Depends on dspid_pkg.
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_ready_o   | line_seen_i, position_error_i, gain_schedule_i
//   out     | out_valid_o / out_ready_i | drive_valid_o, left_wheel_o, right_wheel_o,
//           |                           | train_pulse_o, train_signal_o, searching_o
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A frame that is followed with the line seen reaches the output register after the
// six passes through the single multiplier and the steps that form the gain, round
// the sums and register the result; every other frame goes from idle straight to the
// output step and is registered from there.
// The block takes one frame at a time and is ready again in the same cycle that the
// result is in the output register.
// A stalled output holds the sequencer in its last step.
// Reset restores register defaults and clears all control state.

module differential_steering_pid_with_search_top
  import dspid_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   line_seen_i,
  input  logic signed [ErrW-1:0] position_error_i,
  input  logic signed [ErrW-1:0] gain_schedule_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   drive_valid_o,
  output logic signed [SpdW-1:0] left_wheel_o,
  output logic signed [SpdW-1:0] right_wheel_o,
  output logic                   train_pulse_o,
  output logic signed [ErrW-1:0] train_signal_o,
  output logic                   searching_o
);

  logic [15:0] gain_min_q, gain_max_q, deriv_q, integ_q, alpha_q;
  logic signed [SpdW-1:0] cruise_q;
  logic [7:0] period_q;

  state_e state_q, state_d;

  logic                   mode_q, turn_right_q;
  logic signed [ErrW-1:0] prev_q, filt_q;
  logic signed [SumW-1:0] sum_q;
  logic [7:0]             frame_q;

  logic                   seen_q;
  logic signed [ErrW-1:0] e_q, g_q;
  logic signed [MulAW-1:0] kp_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [SpdW-1:0] left_q, right_q;
  logic                   pulse_q;

  logic                   out_valid_q, drive_q, opulse_q, search_o_q;
  logic signed [SpdW-1:0] oleft_q, oright_q;
  logic signed [ErrW-1:0] tsig_q;

  logic signed [MulAW-1:0]      mul_a;
  logic signed [MulBW-1:0]      mul_b;
  logic signed [MulAW+MulBW-1:0] prod;
  logic                         acc_clr;
  logic                         out_free;
  logic signed [ErrW-1:0]       e_clamped, g_clamped;
  logic signed [AccW-1:0]       kp_round, tot_round, filt_round;
  logic signed [MulAW-1:0]      kp_d;
  logic signed [TotW-1:0]       total, left_raw, right_raw;
  logic signed [SpdW-1:0]       left_sat, right_sat;
  logic signed [SumW:0]         sum_raw;
  logic signed [SumW-1:0]       sum_sat;
  logic [8:0]                   frame_inc;
  logic [7:0]                   period_eff;
  logic signed [ErrW:0]         neg_filt;
  logic signed [ErrW-1:0]       tsig_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    e_clamped = position_error_i;
    if (position_error_i > ErrW'(ErrOne)) begin
      e_clamped = ErrW'(ErrOne);
    end else if (position_error_i < -ErrW'(ErrOne)) begin
      e_clamped = -ErrW'(ErrOne);
    end
    g_clamped = gain_schedule_i;
    if (gain_schedule_i > ErrW'(ErrOne)) begin
      g_clamped = ErrW'(ErrOne);
    end else if (gain_schedule_i < -ErrW'(ErrOne)) begin
      g_clamped = -ErrW'(ErrOne);
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_clr = 1'b1;
    unique case (state_q)
      S_KP_MUL: begin
        mul_a = MulAW'(g_q) + MulAW'(ErrOne);
        mul_b = MulBW'($signed({1'b0, gain_max_q})) - MulBW'($signed({1'b0, gain_min_q}));
      end
      S_P: begin
        mul_a = kp_q;
        mul_b = MulBW'(e_q);
      end
      S_D: begin
        mul_a   = MulAW'($signed({1'b0, deriv_q}));
        mul_b   = MulBW'(e_q) - MulBW'(prev_q);
        acc_clr = 1'b0;
      end
      S_I: begin
        mul_a   = MulAW'($signed({1'b0, integ_q}));
        mul_b   = MulBW'(sum_q);
        acc_clr = 1'b0;
      end
      S_F1: begin
        mul_a = MulAW'($signed({1'b0, alpha_q}));
        mul_b = MulBW'(filt_q);
      end
      S_F2: begin
        mul_a   = MulAW'(1 << AlphaFracBits) - MulAW'($signed({1'b0, alpha_q}));
        mul_b   = MulBW'(e_q);
        acc_clr = 1'b0;
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod  = mul_a * mul_b;
    acc_d = acc_clr ? AccW'(prod) : acc_q + AccW'(prod);
  end

  always_comb begin
    kp_round   = (acc_q + AccW'(1 << ErrFracBits)) >>> (ErrFracBits + 1);
    kp_d       = MulAW'($signed({1'b0, gain_min_q})) + kp_round[MulAW-1:0];
    tot_round  = (acc_q + AccW'(1 << (TotShift - 1))) >>> TotShift;
    total      = tot_round[TotW-1:0];
    left_raw   = TotW'(cruise_q) - total;
    right_raw  = TotW'(cruise_q) + total;
    left_sat   = left_raw[SpdW-1:0];
    if (left_raw > TotW'(SpdLim)) begin
      left_sat = SpdW'(SpdLim);
    end else if (left_raw < -TotW'(SpdLim)) begin
      left_sat = -SpdW'(SpdLim);
    end
    right_sat  = right_raw[SpdW-1:0];
    if (right_raw > TotW'(SpdLim)) begin
      right_sat = SpdW'(SpdLim);
    end else if (right_raw < -TotW'(SpdLim)) begin
      right_sat = -SpdW'(SpdLim);
    end
    filt_round = (acc_q + AccW'(1 << (AlphaFracBits - 1))) >>> AlphaFracBits;
    sum_raw    = (SumW+1)'(sum_q) + (SumW+1)'(e_q);
    sum_sat    = sum_raw[SumW-1:0];
    if (sum_raw > (SumW+1)'(SumLim)) begin
      sum_sat = SumW'(SumLim);
    end else if (sum_raw < -(SumW+1)'(SumLim)) begin
      sum_sat = -SumW'(SumLim);
    end
    frame_inc  = {1'b0, frame_q} + 9'd1;
    period_eff = (period_q == 8'd0) ? 8'd1 : period_q;
    neg_filt   = -(ErrW+1)'(filt_q);
    tsig_d     = neg_filt[ErrW-1:0];
    if (neg_filt > (ErrW+1)'(32767)) begin
      tsig_d = ErrW'(32767);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (!mode_q && line_seen_i) ? S_KP_MUL : S_OUT;
        end
      end
      S_KP_MUL: state_d = S_KP;
      S_KP:     state_d = S_P;
      S_P:      state_d = S_D;
      S_D:      state_d = S_I;
      S_I:      state_d = S_WHEEL;
      S_WHEEL:  state_d = S_F1;
      S_F1:     state_d = S_F2;
      S_F2:     state_d = S_FILT;
      S_FILT:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_min_q <= 16'd512;
      gain_max_q <= 16'd2560;
      deriv_q    <= 16'd256;
      integ_q    <= 16'd16;
      cruise_q   <= 13'sd1280;
      alpha_q    <= 16'd58982;
      period_q   <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_MIN:   gain_min_q <= cfg_data_i;
        REG_GAIN_MAX:   gain_max_q <= cfg_data_i;
        REG_DERIV_COEF: deriv_q    <= cfg_data_i;
        REG_INTEG_COEF: integ_q    <= cfg_data_i;
        REG_CRUISE:     cruise_q   <= cfg_data_i[SpdW-1:0];
        REG_ALPHA:      alpha_q    <= cfg_data_i;
        REG_PERIOD:     period_q   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= 1'b0;
      turn_right_q <= 1'b0;
      prev_q       <= '0;
      filt_q       <= '0;
      sum_q        <= '0;
      frame_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_KP_MUL: sum_q <= sum_sat;
        S_FILT: begin
          filt_q <= filt_round[ErrW-1:0];
          prev_q <= e_q;
          if (frame_inc >= {1'b0, period_eff}) begin
            frame_q <= '0;
          end else begin
            frame_q <= frame_inc[7:0];
          end
          if (e_q > ErrW'(ErrThr) || e_q < -ErrW'(ErrThr)) begin
            turn_right_q <= (e_q > 0);
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (!mode_q && !seen_q) begin
              mode_q <= 1'b1;
              sum_q  <= '0;
            end else if (mode_q && seen_q) begin
              mode_q <= 1'b0;
              sum_q  <= '0;
              prev_q <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      seen_q <= line_seen_i;
      e_q    <= e_clamped;
      g_q    <= g_clamped;
    end
    if (!acc_clr || state_q == S_KP_MUL || state_q == S_P || state_q == S_F1) begin
      acc_q <= acc_d;
    end
    if (state_q == S_KP) begin
      kp_q <= kp_d;
    end
    if (state_q == S_WHEEL) begin
      left_q  <= left_sat;
      right_q <= right_sat;
    end
    if (state_q == S_FILT) begin
      pulse_q <= (frame_inc >= {1'b0, period_eff});
    end
    if (state_q == S_OUT && out_free) begin
      tsig_q <= tsig_d;
      if (!mode_q && seen_q) begin
        drive_q    <= 1'b1;
        oleft_q    <= left_q;
        oright_q   <= right_q;
        opulse_q   <= pulse_q;
        search_o_q <= 1'b0;
      end else if (!mode_q) begin
        drive_q    <= 1'b1;
        oleft_q    <= '0;
        oright_q   <= '0;
        opulse_q   <= 1'b0;
        search_o_q <= 1'b1;
      end else if (seen_q) begin
        drive_q    <= 1'b0;
        oleft_q    <= '0;
        oright_q   <= '0;
        opulse_q   <= 1'b0;
        search_o_q <= 1'b0;
      end else begin
        drive_q    <= 1'b1;
        oleft_q    <= turn_right_q ? SpdW'(TurnSpd) : -SpdW'(TurnSpd);
        oright_q   <= turn_right_q ? -SpdW'(TurnSpd) : SpdW'(TurnSpd);
        opulse_q   <= 1'b0;
        search_o_q <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_valid_o  = drive_q;
  assign left_wheel_o   = oleft_q;
  assign right_wheel_o  = oright_q;
  assign train_pulse_o  = opulse_q;
  assign train_signal_o = tsig_q;
  assign searching_o    = search_o_q;

endmodule

// File: design/dspid_checker.sv
// Port-level checker for the differential steering PID block, attached to
// the top level by a bind statement. Depends on dspid_pkg.

module dspid_checker
  import dspid_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   drive_valid_o,
  input logic signed [SpdW-1:0] left_wheel_o,
  input logic signed [SpdW-1:0] right_wheel_o,
  input logic                   train_pulse_o,
  input logic                   searching_o
);

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a frame was in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before its transfer");

  a_no_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drive_valid_o) |-> (left_wheel_o == '0 && right_wheel_o == '0))
    else $error("wheel speeds nonzero without a drive command");

  a_pulse_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && train_pulse_o) |-> (drive_valid_o && !searching_o))
    else $error("training strobe outside following mode");

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_wheel_o <= SpdW'(SpdLim) && left_wheel_o >= -SpdW'(SpdLim) &&
                     right_wheel_o <= SpdW'(SpdLim) && right_wheel_o >= -SpdW'(SpdLim)))
    else $error("wheel speed beyond saturation limit");

endmodule

bind differential_steering_pid_with_search_top dspid_checker u_dspid_checker (.*);

// File: sim/tb_differential_steering_pid_with_search_top.sv
// Self-checking testbench for differential_steering_pid_with_search_top: random frames with
// random handshake stalls, checked against a cycle-free predictor of the steering law.
// Depends on dspid_pkg and the top level of the block.

module tb_differential_steering_pid_with_search_top;
  import dspid_pkg::*;

  localparam int LongHoldCycles = 300;
  localparam int WatchdogLimit  = 2000;
  localparam int ItemsPerPhase  = 240;
  localparam int NumPhases      = 8;

  typedef struct packed {
    logic                   seen;
    logic signed [ErrW-1:0] pos_err;
    logic signed [ErrW-1:0] sched;
  } frame_t;

  typedef struct packed {
    logic                   drive;
    logic signed [SpdW-1:0] left;
    logic signed [SpdW-1:0] right;
    logic                   pulse;
    logic signed [ErrW-1:0] train;
    logic                   search;
  } cmd_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   line_seen_i = 1'b0;
  logic signed [ErrW-1:0] position_error_i = '0;
  logic signed [ErrW-1:0] gain_schedule_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   drive_valid_o;
  logic signed [SpdW-1:0] left_wheel_o;
  logic signed [SpdW-1:0] right_wheel_o;
  logic                   train_pulse_o;
  logic signed [ErrW-1:0] train_signal_o;
  logic                   searching_o;

  differential_steering_pid_with_search_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .line_seen_i     (line_seen_i),
    .position_error_i(position_error_i),
    .gain_schedule_i (gain_schedule_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_valid_o   (drive_valid_o),
    .left_wheel_o    (left_wheel_o),
    .right_wheel_o   (right_wheel_o),
    .train_pulse_o   (train_pulse_o),
    .train_signal_o  (train_signal_o),
    .searching_o     (searching_o)
  );

  always #5 clk_i = ~clk_i;

  frame_t frames_pending[$];
  cmd_t   commands_due[$];

  longint kp_lo = 512, kp_hi = 2560, kd = 256, ki = 16;
  longint cruise = 1280, alpha = 58982, period = 10;

  bit     searching_now = 1'b0;
  bit     turn_right = 1'b0;
  longint prev_err = 0, err_sum = 0, filt_err = 0;
  int     frame_cnt = 0;

  int  errors = 0;
  int  n_frames = 0, n_follow = 0, n_turns = 0, n_pulses = 0, n_settings = 1;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  in_gap = 0, out_gap = 0;
  int  quiet_cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic cmd_t steer_frame(frame_t f);
    longint e, g, kp, acc, total, per;
    cmd_t   c;
    c = '0;
    e = clip(longint'(f.pos_err), -ErrOne, ErrOne);
    g = clip(longint'(f.sched), -ErrOne, ErrOne);
    n_frames++;
    if (!searching_now) begin
      if (f.seen) begin
        per = (period == 0) ? 1 : period;
        err_sum = clip(err_sum + e, -SumLim, SumLim);
        kp = kp_lo + round_half_up((g + ErrOne) * (kp_hi - kp_lo), ErrFracBits + 1);
        acc = kp * e + kd * (e - prev_err) + ki * err_sum;
        total = round_half_up(acc, TotShift);
        c.left = SpdW'(clip(cruise - total, -SpdLim, SpdLim));
        c.right = SpdW'(clip(cruise + total, -SpdLim, SpdLim));
        c.drive = 1'b1;
        prev_err = e;
        filt_err = round_half_up(alpha * filt_err + (65536 - alpha) * e, AlphaFracBits);
        if (frame_cnt + 1 >= per) begin
          c.pulse = 1'b1;
          frame_cnt = 0;
          n_pulses++;
        end else begin
          frame_cnt = (frame_cnt + 1) & 255;
        end
        if (e > ErrThr || e < -ErrThr) begin
          turn_right = (e > 0);
        end
        n_follow++;
      end else begin
        searching_now = 1'b1;
        err_sum = 0;
        c.drive = 1'b1;
      end
    end else if (f.seen) begin
      searching_now = 1'b0;
      prev_err = 0;
      err_sum = 0;
    end else begin
      c.drive = 1'b1;
      c.left = SpdW'(turn_right ? TurnSpd : -TurnSpd);
      c.right = SpdW'(turn_right ? -TurnSpd : TurnSpd);
      n_turns++;
    end
    c.train = ErrW'(clip(-filt_err, -32768, 32767));
    c.search = searching_now;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_command(cmd_t got, cmd_t want);
    if (got.drive !== want.drive) report_mismatch("drive_valid", got.drive, want.drive);
    if (got.left !== want.left) report_mismatch("left_wheel", got.left, want.left);
    if (got.right !== want.right) report_mismatch("right_wheel", got.right, want.right);
    if (got.pulse !== want.pulse) report_mismatch("train_pulse", got.pulse, want.pulse);
    if (got.train !== want.train) report_mismatch("train_signal", got.train, want.train);
    if (got.search !== want.search) report_mismatch("searching", got.search, want.search);
  endtask

  task automatic push_frame(bit seen, int e, int g);
    frame_t f;
    f.seen = seen;
    f.pos_err = ErrW'(e);
    f.sched = ErrW'(g);
    frames_pending.insert(frames_pending.size(), f);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_GAIN_MIN:   kp_lo = longint'(val);
      REG_GAIN_MAX:   kp_hi = longint'(val);
      REG_DERIV_COEF: kd = longint'(val);
      REG_INTEG_COEF: ki = longint'(val);
      REG_CRUISE:     cruise = longint'($signed(val[SpdW-1:0]));
      REG_ALPHA:      alpha = longint'(val);
      REG_PERIOD:     period = longint'(val[7:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int gmin, int gmax, int d, int i, int speed, int a, int per);
    write_reg(REG_GAIN_MIN, CfgW'(gmin));
    write_reg(REG_GAIN_MAX, CfgW'(gmax));
    write_reg(REG_DERIV_COEF, CfgW'(d));
    write_reg(REG_INTEG_COEF, CfgW'(i));
    write_reg(REG_CRUISE, CfgW'(speed));
    write_reg(REG_ALPHA, CfgW'(a));
    write_reg(REG_PERIOD, CfgW'(per));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (frames_pending.size() != 0 || in_valid_i || commands_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int any_value();
    return int'($signed(ErrW'($urandom)));
  endfunction

  function automatic int unit_value();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Mostly tracking runs with an error scattered about a base value, broken by lost-line bursts and noise.
  task automatic queue_random_frames(int count);
    int pushed, kind, len, base, spread, e, g, k;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        len = $urandom_range(3, 40);
        base = unit_value();
        spread = $urandom_range(0, 4000);
        for (k = 0; k < len; k++) begin
          e = base + int'($urandom_range(0, 2 * spread)) - spread;
          if ($urandom_range(0, 19) == 0) e = any_value();
          g = ($urandom_range(0, 9) == 0) ? any_value() : unit_value();
          push_frame(1'b1, e, g);
        end
      end else if (kind < 95) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          push_frame(1'b0, ($urandom_range(0, 9) == 0) ? any_value() : 0, any_value());
        end
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          push_frame(1'($urandom_range(0, 1)), any_value(), any_value());
        end
      end
      pushed += len;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_frames
    frame_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      line_seen_i <= 1'b0;
      position_error_i <= '0;
      gain_schedule_i <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        commands_due.insert(commands_due.size(),
                            steer_frame({line_seen_i, position_error_i, gain_schedule_i}));
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 11);
        in_valid_i <= 1'b0;
      end else if (frames_pending.size() != 0) begin
        nxt = frames_pending.pop_front();
        line_seen_i <= nxt.seen;
        position_error_i <= nxt.pos_err;
        gain_schedule_i <= nxt.sched;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_commands
    cmd_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.drive = drive_valid_o;
        got.left = left_wheel_o;
        got.right = right_wheel_o;
        got.pulse = train_pulse_o;
        got.train = train_signal_o;
        got.search = searching_o;
        if (commands_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.drive, 0);
        end else begin
          check_command(got, commands_due.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        if (hold_cnt == LongHoldCycles - 1) hold_done <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("Watchdog expired after %0d cycles without a transfer.", WatchdogLimit);
      $display("** differential_steering_pid_with_search_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes, saturation, the turn threshold, and every mode change.
    push_frame(1'b1, 0, 0);
    push_frame(1'b1, 16384, 16384);
    push_frame(1'b1, -16384, -16384);
    push_frame(1'b1, 32767, 32767);
    push_frame(1'b1, -32768, -32768);
    push_frame(1'b1, ErrThr, 0);
    push_frame(1'b1, ErrThr + 1, 0);
    push_frame(1'b1, -ErrThr, 100);
    push_frame(1'b0, 0, 0);
    push_frame(1'b0, 0, 0);
    push_frame(1'b0, -5000, 0);
    push_frame(1'b1, 3000, 0);
    push_frame(1'b1, -8000, 8000);
    push_frame(1'b0, 0, 0);
    push_frame(1'b0, 0, 0);
    push_frame(1'b1, 0, 0);
    push_frame(1'b0, 0, 0);
    push_frame(1'b1, 0, 0);
    push_frame(1'b1, 16384, -16384);
    push_frame(1'b1, -ErrThr - 1, 16383);
    push_frame(1'b1, 1, -1);
    push_frame(1'b1, -1, 1);
    wait_drained();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: hold_req = 1'b1;
        1: apply_settings(65535, 0, 65535, 65535, 2560, 65535, 255);
        2: apply_settings(0, 65535, 0, 0, -2560, 0, 0);
        3: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095), 300, 40, 0, 60000,
                          255);
        4: apply_settings($urandom, $urandom, $urandom, $urandom,
                          int'($urandom_range(0, 5120)) - 2560, $urandom, 3);
        default: apply_settings($urandom, $urandom, $urandom_range(0, 2048),
                                $urandom_range(0, 256), int'($urandom_range(0, 5120)) - 2560,
                                $urandom, $urandom_range(1, 40));
      endcase
      idle_en = (ph != 5 && ph != NumPhases - 1);
      queue_random_frames(ItemsPerPhase);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d frames over %0d register settings: %0d tracked, %0d search turns,",
             n_frames, n_settings, n_follow, n_turns);
    $display("%0d training strobes, with one long output stall; %0d mismatches.",
             n_pulses, errors);
    if (errors == 0) begin
      $display("** differential_steering_pid_with_search_top: PASSED **");
    end else begin
      $display("** differential_steering_pid_with_search_top: FAILED **");
    end
    $finish;
  end

endmodule
